// File: src/lopf_pkg.sv
// Package for the line offset PD follower: types, register map, codes.
// Used by every module in src; depends on nothing.
package lopf_pkg;

    localparam int unsigned DivSteps = 16;

    typedef enum logic [1:0] {
        ACT_BEGIN = 2'd0,
        ACT_FRAME = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_ALPHA = 3'd0,
        REG_KP    = 3'd1,
        REG_KD    = 3'd2,
        REG_LIM   = 3'd3,
        REG_MINL  = 3'd4,
        REG_TOUT  = 3'd5,
        REG_GAP   = 3'd6,
        REG_UNUSED = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [15:0]        alpha;
        logic signed [15:0] kp;
        logic signed [15:0] kd;
        logic [14:0]        lim;
        logic [14:0]        minl;
        logic [15:0]        tout;
        logic [15:0]        gap;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch the input item
        logic do_begin;
        logic do_tick;
        logic do_check;  // compute lengths
        logic do_invalid;
        logic do_prime;
        logic do_ema_mul;
        logic do_ema_sum;
        logic div_start;
        logic div_step;
        logic div_end;
        logic do_pd_mul;
        logic do_pd_sum;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_frame;
        logic valid;
        logic primed;
        logic use_div;
        logic div_last;
    } t_status;

endpackage

// File: src/lopf_ctrl.sv
// Controller state machine for the line offset PD follower.
// Depends on lopf_pkg.
module lopf_ctrl import lopf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHECK = 10'b0000000010,
        S_DEC   = 10'b0000000100,
        S_EMAM  = 10'b0000001000,
        S_EMAS  = 10'b0000010000,
        S_DIV   = 10'b0000100000,
        S_DEND  = 10'b0001000000,
        S_PDM   = 10'b0010000000,
        S_PDS   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_take;
    logic   w_busy;

    assign w_busy     = (r_state != S_IDLE);
    assign o_in_ready = !w_busy && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign w_take     = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.do_check = 1'b1;
                n_state        = S_DEC;
            end
            S_DEC: begin
                if (!i_st.is_frame) begin
                    o_cmd.do_begin = 1'b1;
                    o_cmd.do_tick  = 1'b1;
                    n_state        = S_OUT;
                end else if (!i_st.valid) begin
                    o_cmd.do_invalid = 1'b1;
                    n_state          = S_OUT;
                end else if (!i_st.primed) begin
                    o_cmd.do_prime = 1'b1;
                    n_state        = S_PDM;
                end else begin
                    o_cmd.do_ema_mul = 1'b1;
                    n_state          = S_EMAS;
                end
            end
            S_EMAS: begin
                o_cmd.do_ema_sum = 1'b1;
                o_cmd.div_start  = 1'b1;
                n_state          = i_st.use_div ? S_DIV : S_PDM;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_st.div_last) begin
                    n_state = S_DEND;
                end
            end
            S_DEND: begin
                o_cmd.div_end = 1'b1;
                n_state       = S_PDM;
            end
            S_PDM: begin
                o_cmd.do_pd_mul = 1'b1;
                n_state         = S_PDS;
            end
            S_PDS: begin
                o_cmd.do_pd_sum = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_EMAM: begin
                n_state = S_EMAS;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !o_in_ready) else $error("ready while busy");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> r_out_valid) else $error("result not posted");

endmodule

// File: src/lopf_dp.sv
// Datapath for the line offset PD follower: filter, divider, PD, counters.
// Depends on lopf_pkg; commanded by lopf_ctrl.
module lopf_dp import lopf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_cmd               i_cmd,
    input  logic [1:0]         i_action,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic               i_ok,
    output t_status            o_st,
    output logic signed [15:0] o_fwd,
    output logic signed [15:0] o_lat,
    output logic               o_active,
    output logic               o_lost
);

    logic [1:0]         r_act;
    logic signed [15:0] r_x, r_y;
    logic               r_ok;
    logic signed [15:0] r_fx, r_fy;
    logic               r_primed, r_seen, r_armed, r_valid;
    logic signed [15:0] r_hf, r_hl;
    logic [15:0]        r_tsv, r_tsf;
    logic signed [33:0] r_mx0, r_mx1, r_my0, r_my1;
    logic signed [16:0] r_dfx, r_dfy;
    logic [16:0]        r_remx, r_remy;
    logic [15:0]        r_qx, r_qy;
    logic [4:0]         r_cnt;
    logic               r_negx, r_negy;
    logic signed [16:0] r_dx, r_dy;
    logic signed [33:0] r_pf0, r_pf1, r_pl0, r_pl1;
    logic [15:0]        r_gap;

    logic [15:0]        w_a, w_ia;
    logic [32:0]        w_len2, w_min2;
    logic signed [34:0] w_accx, w_accy;
    logic signed [15:0] w_nfx, w_nfy;
    logic signed [16:0] w_difx, w_dify;
    logic [16:0]        w_trx, w_try;
    logic signed [34:0] w_cf, w_cl;

    assign w_a  = (i_cfg.alpha > 16'd32768) ? 16'd32768 : i_cfg.alpha;
    assign w_ia = 16'd32768 - w_a;
    assign w_len2 = {1'b0, 32'(r_x * r_x)} + {1'b0, 32'(r_y * r_y)};
    assign w_min2 = {3'b0, 30'(i_cfg.minl * i_cfg.minl)};

    assign w_accx = 35'(r_mx0) + 35'(r_mx1) + 35'sd16384;
    assign w_accy = 35'(r_my0) + 35'(r_my1) + 35'sd16384;
    assign w_nfx  = 16'(w_accx >>> 15);
    assign w_nfy  = 16'(w_accy >>> 15);
    assign w_difx = 17'(w_nfx) - 17'(r_fx);
    assign w_dify = 17'(w_nfy) - 17'(r_fy);

    // restoring divide, one quotient bit per step on magnitudes
    assign w_trx = {r_remx[15:0], r_dfx[15]} - {1'b0, r_gap};
    assign w_try = {r_remy[15:0], r_dfy[15]} - {1'b0, r_gap};

    assign w_cf = 35'(r_pf0) + 35'(r_pf1) + 35'sd128;
    assign w_cl = 35'(r_pl0) + 35'(r_pl1) + 35'sd128;

    function automatic logic signed [15:0] clampc(input logic signed [34:0] c,
                                                  input logic [14:0] lim);
        logic signed [34:0] s;
        logic signed [34:0] l;
        s = c >>> 8;
        l = 35'(lim);
        if (s > l) clampc = 16'(l);
        else if (s < -l) clampc = 16'(-l);
        else clampc = 16'(s);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_x   <= i_x;
            r_y   <= i_y;
            r_ok  <= i_ok;
        end
        if (i_cmd.do_check) begin
            r_valid <= r_ok && (w_len2 >= w_min2);
        end
        if (i_cmd.do_ema_mul) begin
            r_mx0 <= 34'(r_x * $signed({1'b0, w_a}));
            r_mx1 <= 34'(r_fx * $signed({1'b0, w_ia}));
            r_my0 <= 34'(r_y * $signed({1'b0, w_a}));
            r_my1 <= 34'(r_fy * $signed({1'b0, w_ia}));
            r_gap <= r_tsf;
        end
        if (i_cmd.div_start) begin
            r_negx <= w_difx[16];
            r_negy <= w_dify[16];
            r_dfx  <= w_difx[16] ? -w_difx : w_difx;
            r_dfy  <= w_dify[16] ? -w_dify : w_dify;
            r_remx <= '0;
            r_remy <= '0;
            r_cnt  <= '0;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 5'd1;
            r_dfx <= {r_dfx[15:0], 1'b0};
            r_dfy <= {r_dfy[15:0], 1'b0};
            r_qx  <= {r_qx[14:0], !w_trx[16]};
            r_qy  <= {r_qy[14:0], !w_try[16]};
            r_remx <= w_trx[16] ? {r_remx[15:0], r_dfx[15]} : w_trx;
            r_remy <= w_try[16] ? {r_remy[15:0], r_dfy[15]} : w_try;
        end
        if (i_cmd.do_pd_mul) begin
            r_pf0 <= 34'(i_cfg.kp * r_fx);
            r_pl0 <= 34'(i_cfg.kp * r_fy);
            r_pf1 <= 34'(i_cfg.kd * r_dx);
            r_pl1 <= 34'(i_cfg.kd * r_dy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx <= '0; r_fy <= '0;
            r_primed <= 1'b0; r_seen <= 1'b0; r_armed <= 1'b0;
            r_hf <= '0; r_hl <= '0; r_tsv <= '0; r_tsf <= '0;
            r_dx <= '0; r_dy <= '0;
        end else begin
            if (i_cmd.do_begin && r_act == ACT_BEGIN) begin
                r_armed <= 1'b1; r_tsv <= '0; r_seen <= 1'b0; r_primed <= 1'b0;
                r_fx <= '0; r_fy <= '0; r_hf <= '0; r_hl <= '0;
            end
            if (i_cmd.do_tick && r_act == ACT_TICK) begin
                if (r_tsv != 16'hFFFF) r_tsv <= r_tsv + 16'd1;
                if (r_tsf != 16'hFFFF) r_tsf <= r_tsf + 16'd1;
            end
            if (i_cmd.do_invalid) begin
                r_seen <= 1'b0; r_primed <= 1'b0;
                r_fx <= '0; r_fy <= '0; r_hf <= '0; r_hl <= '0;
            end
            if (i_cmd.do_prime) begin
                r_seen <= 1'b1; r_tsv <= '0; r_tsf <= '0; r_primed <= 1'b1;
                r_fx <= r_x; r_fy <= r_y; r_dx <= '0; r_dy <= '0;
            end
            if (i_cmd.do_ema_sum) begin
                r_seen <= 1'b1; r_tsv <= '0; r_tsf <= '0;
                r_fx <= w_nfx; r_fy <= w_nfy; r_dx <= '0; r_dy <= '0;
            end
            if (i_cmd.div_end) begin
                r_dx <= r_negx ? -$signed({1'b0, r_qx}) : $signed({1'b0, r_qx});
                r_dy <= r_negy ? -$signed({1'b0, r_qy}) : $signed({1'b0, r_qy});
            end
            if (i_cmd.do_pd_sum) begin
                r_hf <= clampc(w_cf, i_cfg.lim);
                r_hl <= clampc(w_cl, i_cfg.lim);
            end
        end
    end

    assign o_st.is_frame = (r_act == ACT_FRAME);
    assign o_st.valid    = r_valid;
    assign o_st.primed   = r_primed;
    assign o_st.use_div  = (r_gap != 16'd0) && (r_gap < i_cfg.gap);
    assign o_st.div_last = (r_cnt == 5'(DivSteps - 1));
    assign o_fwd    = r_hf;
    assign o_lat    = r_hl;
    assign o_active = r_seen;
    assign o_lost   = r_armed && (r_tsv >= i_cfg.tout);

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.do_pd_sum) |-> (r_hf <= $signed({1'b0, i_cfg.lim})))
        else $error("command beyond limit");
    a_seen_tsv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_prime || i_cmd.do_ema_sum) |=> (r_tsv == 16'd0))
        else $error("valid frame left counter");
    a_inval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_invalid |=> (!r_primed && r_hf == 16'sd0))
        else $error("invalid frame left state");

endmodule

// File: src/line_offset_pd_follower.sv
// Top level of the line offset PD follower: APB registers, controller, datapath.
// Depends on lopf_pkg, lopf_ctrl, lopf_dp.
//
//  channel | dir | handshake            | payload
//  s_axis  | in  | tvalid/tready        | tdata {frame_ok,y,x}, tuser action
//  m_axis  | out | tvalid/tready        | tdata {lost,active,lat,fwd}
//  apb     | in  | psel/penable/pwrite  | 7 regs at 4*i, pready always 1
//
// Begin, tick and invalid frame: check, decode, result. A first valid frame adds
// the PD multiply and sum; a filtered frame adds the EMA multiply and sum, the
// derivative divide when it runs (16-step restoring divider), and the PD steps.
// One item in flight; next accepted once the result register is free. Synchronous active-low reset restores defaults.
module line_offset_pd_follower import lopf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] line_x, [31:16] line_y, [32] frame_ok, zero fill
    input  logic [39:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] forward_speed, [31:16] lateral_speed, [32] line_active,
    // [33] lost_timeout, zero fill
    output logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    r_cfg;
    t_cmd    w_cmd;
    t_status w_st;
    t_reg_idx w_idx;
    logic signed [15:0] w_fwd, w_lat;
    logic    w_act, w_lost;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha <= 16'd16384;
            r_cfg.kp    <= 16'sd256;
            r_cfg.kd    <= 16'sd0;
            r_cfg.lim   <= 15'd2048;
            r_cfg.minl  <= 15'd41;
            r_cfg.tout  <= 16'd1000;
            r_cfg.gap   <= 16'd1000;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_ALPHA: r_cfg.alpha <= pwdata[15:0];
                REG_KP:    r_cfg.kp    <= pwdata[15:0];
                REG_KD:    r_cfg.kd    <= pwdata[15:0];
                REG_LIM:   r_cfg.lim   <= pwdata[14:0];
                REG_MINL:  r_cfg.minl  <= pwdata[14:0];
                REG_TOUT:  r_cfg.tout  <= pwdata[15:0];
                REG_GAP:   r_cfg.gap   <= pwdata[15:0];
                REG_UNUSED: ;
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_ALPHA: prdata = {16'd0, r_cfg.alpha};
            REG_KP:    prdata = {16'd0, r_cfg.kp};
            REG_KD:    prdata = {16'd0, r_cfg.kd};
            REG_LIM:   prdata = {17'd0, r_cfg.lim};
            REG_MINL:  prdata = {17'd0, r_cfg.minl};
            REG_TOUT:  prdata = {16'd0, r_cfg.tout};
            REG_GAP:   prdata = {16'd0, r_cfg.gap};
            REG_UNUSED: prdata = '0;
            default:   prdata = '0;
        endcase
    end

    lopf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_st        (w_st),
        .o_cmd       (w_cmd)
    );

    lopf_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cmd    (w_cmd),
        .i_action (s_axis_tuser),
        .i_x      (s_axis_tdata[15:0]),
        .i_y      (s_axis_tdata[31:16]),
        .i_ok     (s_axis_tdata[32]),
        .o_st     (w_st),
        .o_fwd    (w_fwd),
        .o_lat    (w_lat),
        .o_active (w_act),
        .o_lost   (w_lost)
    );

    assign m_axis_tdata = {6'd0, w_lost, w_act, w_lat, w_fwd};

endmodule

// File: tb/lopf_checker.sv
// Checker for the line offset PD follower: watches both stream channels and the
// APB port, predicts each result from its own state copy and compares in order.
// Depends on lopf_pkg.
module lopf_checker import lopf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        lost;
        logic        active;
        logic [15:0] lat;
        logic [15:0] fwd;
    } t_cmd_out;

    t_cfg cfg;
    logic signed [15:0] filt_x, filt_y, held_fwd, held_lat;
    logic primed, seen, armed;
    logic [15:0] tsv, tsf;
    t_cmd_out cmd_queue[$];
    int fails;

    assign o_fail_count = fails;
    assign o_pending = cmd_queue.size();

    function automatic logic signed [63:0] rnd_shift(logic signed [63:0] v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] pd_cmd(logic signed [15:0] f,
                                                  logic signed [31:0] d);
        logic signed [63:0] c, lim;
        lim = $signed({49'd0, cfg.lim});
        c = rnd_shift($signed(cfg.kp) * 64'(f) + $signed(cfg.kd) * 64'(d), 8);
        if (c > lim) c = lim;
        if (c < -lim) c = -lim;
        return c[15:0];
    endfunction

    function automatic logic signed [15:0] ema_step(logic signed [15:0] raw,
                                                    logic signed [15:0] old,
                                                    logic [15:0] a);
        logic signed [63:0] acc;
        acc = $signed({48'd0, a}) * 64'(raw) + $signed(64'd32768 - a) * 64'(old);
        return 16'(rnd_shift(acc, 15));
    endfunction

    task automatic predict_frame(logic signed [15:0] x, logic signed [15:0] y, logic ok);
        logic [63:0] len2, min2;
        logic [15:0] a;
        logic signed [15:0] px, py;
        logic signed [31:0] dx, dy;
        len2 = 64'(32'(x) * 32'(x)) + 64'(32'(y) * 32'(y));
        min2 = 64'(cfg.minl) * 64'(cfg.minl);
        dx = 0;
        dy = 0;
        seen = ok && len2 >= min2;
        if (!seen) begin
            primed = 0; filt_x = 0; filt_y = 0; held_fwd = 0; held_lat = 0;
        end else begin
            tsv = 0;
            if (!primed) begin
                filt_x = x; filt_y = y; primed = 1;
            end else begin
                a = (cfg.alpha > 16'd32768) ? 16'd32768 : cfg.alpha;
                px = filt_x;
                py = filt_y;
                filt_x = ema_step(x, px, a);
                filt_y = ema_step(y, py, a);
                if (tsf > 0 && tsf < cfg.gap) begin
                    dx = (32'(filt_x) - 32'(px)) / $signed({16'd0, tsf});
                    dy = (32'(filt_y) - 32'(py)) / $signed({16'd0, tsf});
                end
            end
            tsf = 0;
            held_fwd = pd_cmd(filt_x, dx);
            held_lat = pd_cmd(filt_y, dy);
        end
    endtask

    always @(posedge i_clk) begin
        t_cmd_out exp_r, got;
        if (!i_rst_n) begin
            cfg = '{alpha: 16384, kp: 256, kd: 0, lim: 2048, minl: 41, tout: 1000,
                    gap: 1000};
            filt_x = 0; filt_y = 0; primed = 0; held_fwd = 0; held_lat = 0;
            seen = 0; armed = 0; tsv = 0; tsf = 0;
            cmd_queue.delete();
            fails = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_ALPHA: cfg.alpha = pwdata[15:0];
                    REG_KP:    cfg.kp = pwdata[15:0];
                    REG_KD:    cfg.kd = pwdata[15:0];
                    REG_LIM:   cfg.lim = pwdata[14:0];
                    REG_MINL:  cfg.minl = pwdata[14:0];
                    REG_TOUT:  cfg.tout = pwdata[15:0];
                    REG_GAP:   cfg.gap = pwdata[15:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[33:0];
                if (cmd_queue.size() == 0) begin
                    $error("unexpected result item %h", m_axis_tdata);
                    fails++;
                end else begin
                    exp_r = cmd_queue.pop_front();
                    if (got.fwd !== exp_r.fwd) begin
                        $error("forward_speed exp %h got %h", exp_r.fwd, got.fwd);
                        fails++;
                    end
                    if (got.lat !== exp_r.lat) begin
                        $error("lateral_speed exp %h got %h", exp_r.lat, got.lat);
                        fails++;
                    end
                    if (got.active !== exp_r.active) begin
                        $error("line_active exp %b got %b", exp_r.active, got.active);
                        fails++;
                    end
                    if (got.lost !== exp_r.lost) begin
                        $error("lost_timeout exp %b got %b", exp_r.lost, got.lost);
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                case (t_action'(s_axis_tuser))
                    ACT_BEGIN: begin
                        armed = 1; tsv = 0; seen = 0; primed = 0;
                        filt_x = 0; filt_y = 0; held_fwd = 0; held_lat = 0;
                    end
                    ACT_FRAME: predict_frame(s_axis_tdata[15:0], s_axis_tdata[31:16],
                                             s_axis_tdata[32]);
                    ACT_TICK: begin
                        if (tsv != 16'hFFFF) tsv++;
                        if (tsf != 16'hFFFF) tsf++;
                    end
                    default: ;
                endcase
                cmd_queue.push_back('{lost: armed && tsv >= cfg.tout, active: seen,
                                      lat: held_lat, fwd: held_fwd});
            end
        end
    end
endmodule

// File: tb/tb_line_offset_pd_follower.sv
// Testbench top for the line offset PD follower: clock, reset, register phases,
// directed and random item streams with idling. Depends on lopf_pkg, lopf_checker.
module tb_line_offset_pd_follower;
    timeunit 1ns;
    timeprecision 1ps;
    import lopf_pkg::*;

    logic i_clk = 0, i_rst_n = 0;
    logic s_axis_tvalid = 0, m_axis_tready = 0;
    logic s_axis_tready, m_axis_tvalid, pready;
    logic [39:0] s_axis_tdata = '0, m_axis_tdata;
    logic [1:0] s_axis_tuser = '0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    int fail_count, pending;
    int send_idle = 0, recv_idle = 0;
    int quiet_cycles = 0;

    always #1 i_clk = ~i_clk;

    line_offset_pd_follower i_dut (.*);
    lopf_checker i_chk (.*, .o_fail_count(fail_count), .o_pending(pending));

    // receiver stall pattern, changed on the falling edge
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle);

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("line_offset_pd_follower: mismatch");
            $finish;
        end
    end

    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_item(t_action act, logic [15:0] x, logic [15:0] y, logic ok);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= act;
        s_axis_tdata <= {7'd0, ok, y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    // random items: frames mostly near the valid range, sometimes extreme, mixed with begin, tick and no-action items
    task automatic rand_items(int n);
        logic [15:0] x, y;
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            x = (r < 70) ? 16'($signed($urandom_range(8000)) - 4000) : 16'($urandom);
            y = (r < 70) ? 16'($signed($urandom_range(8000)) - 4000) : 16'($urandom);
            r = $urandom_range(99);
            if (r < 3) send_item(ACT_BEGIN, 16'($urandom), 16'($urandom), 1'($urandom));
            else if (r < 5)
                send_item(ACT_NONE, 16'($urandom), 16'($urandom), 1'($urandom));
            else if (r < 45) send_item(ACT_FRAME, x, y, $urandom_range(99) < 90);
            else send_item(ACT_TICK, 16'($urandom), 16'($urandom), 1'($urandom));
        end
    endtask

    task automatic rand_config();
        reg_write(REG_ALPHA, $urandom_range(65535));
        reg_write(REG_KP, $urandom);
        reg_write(REG_KD, $urandom);
        reg_write(REG_LIM, $urandom);
        reg_write(REG_MINL, $urandom_range(3000));
        reg_write(REG_TOUT, $urandom_range(40));
        reg_write(REG_GAP, $urandom_range(1, 30));
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        send_idle = 27; recv_idle = 59;
        // directed: defaults, then extremes
        send_item(ACT_NONE, 0, 0, 0);
        send_item(ACT_BEGIN, 0, 0, 0);
        send_item(ACT_FRAME, 16'h7FFF, 16'h8000, 1);
        send_item(ACT_TICK, 0, 0, 0);
        send_item(ACT_FRAME, 16'h8000, 16'h7FFF, 1);
        send_item(ACT_FRAME, 16'd10, 16'd10, 1);
        send_item(ACT_FRAME, 16'd500, 16'd500, 0);
        send_item(ACT_FRAME, 16'hFFFF, 16'hFFFF, 1);
        drain();
        reg_write(REG_ALPHA, 32768 + 100);
        reg_write(REG_KP, 32'h7FFF);
        reg_write(REG_KD, 32'h8000);
        reg_write(REG_LIM, 32'h7FFF);
        reg_write(REG_MINL, 0);
        reg_write(REG_TOUT, 0);
        reg_write(REG_GAP, 32'hFFFF);
        reg_write(REG_UNUSED, 32'hFFFF_FFFF);
        send_item(ACT_BEGIN, 0, 0, 0);
        send_item(ACT_FRAME, 0, 0, 1);
        send_item(ACT_TICK, 0, 0, 0);
        send_item(ACT_FRAME, 16'h7FFF, 16'h8000, 1);
        send_item(ACT_TICK, 0, 0, 0);
        send_item(ACT_TICK, 0, 0, 0);
        send_item(ACT_FRAME, 16'h8000, 16'h7FFF, 1);
        drain();
        reg_write(REG_ALPHA, 0);
        reg_write(REG_MINL, 32'h7FFF);
        reg_write(REG_GAP, 1);
        send_item(ACT_FRAME, 16'h7FFF, 16'h7FFF, 1);
        send_item(ACT_FRAME, 16'h8000, 16'h8000, 1);
        drain();
        // long tick run back to back, then a frame
        reg_write(REG_MINL, 41);
        reg_write(REG_TOUT, 32'hFFFF);
        send_idle = 0; recv_idle = 0;
        repeat (30) send_item(ACT_TICK, 0, 0, 0);
        send_item(ACT_FRAME, 16'd2000, 16'd100, 1);
        drain();
        for (int ph = 0; ph < 9; ph++) begin
            send_idle = (ph < 3) ? 27 : (ph < 6) ? 59 : 0;
            recv_idle = (ph < 3) ? 59 : (ph < 6) ? 27 : 0;
            rand_config();
            send_item(ACT_BEGIN, 0, 0, 0);
            rand_items(190);
            drain();
        end
        if (fail_count == 0)
            $display("line_offset_pd_follower: match");
        else
            $display("line_offset_pd_follower: mismatch");
        $finish;
    end
endmodule

// File: files.f
src/lopf_pkg.sv
src/lopf_ctrl.sv
src/lopf_dp.sv
src/line_offset_pd_follower.sv
tb/lopf_checker.sv
tb/tb_line_offset_pd_follower.sv
